>>> rtl/decimal_argument_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Decimal argument parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ARGUMENT_PARSER_TOP_MACROS_SVH
`define DECIMAL_ARGUMENT_PARSER_TOP_MACROS_SVH

// Same-cycle implication.
`define DAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DAP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dap_pkg.sv
// ----------------------------------------------------------------------------
// Decimal argument parser package
// Widths, character codes, parse phases, status codes and the end-of-string
// record passed from the parse core to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dap_pkg;

    localparam int MAX_ARGS_DEF = 4;
    localparam int OUT_ARGS     = 4;
    localparam int BYTE_W       = 8;
    localparam int VAL_W        = 32;
    localparam int STAT_W       = 2;
    localparam int CNT_W        = 3;
    localparam int PHASE_W      = 2;
    localparam int OUT_DATA_W   = 136;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;

    localparam logic [PHASE_W-1:0] PH_LEAD = 2'd0;
    localparam logic [PHASE_W-1:0] PH_NUM  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_GAP  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd0;
    localparam logic [STAT_W-1:0] ST_HELP    = 2'd1;
    localparam logic [STAT_W-1:0] ST_CORRECT = 2'd2;
    localparam logic [STAT_W-1:0] ST_ERROR   = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
    } t_emit;

endpackage

>>> rtl/dap_parse_core.sv
// ----------------------------------------------------------------------------
// Decimal argument parser core
// Per-byte parse state and argument accumulators; reports the end-of-string
// result combinationally for the byte being transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dap_parse_core #(
    parameter int MAX_ARGS = dap_pkg::MAX_ARGS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_take,
    input  logic [dap_pkg::BYTE_W-1:0] i_byte,
    output dap_pkg::t_emit            o_emit,
    output logic [dap_pkg::VAL_W-1:0] o_values [dap_pkg::OUT_ARGS]
);

    localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;

    logic [dap_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [dap_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic [dap_pkg::STAT_W-1:0]  r_held, n_held;
    logic [dap_pkg::VAL_W-1:0]   r_acc [MAX_ARGS];

    logic                      is_digit, is_space, is_nul;
    logic [dap_pkg::VAL_W-1:0] digit_val;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_k;
    logic [dap_pkg::VAL_W-1:0] wr_val;
    logic [dap_pkg::CNT_W-1:0] idx_less1;
    logic [dap_pkg::VAL_W-1:0] acc_cur;

    assign is_digit  = (i_byte >= dap_pkg::CH_ZERO) && (i_byte <= dap_pkg::CH_NINE);
    assign is_space  = (i_byte == dap_pkg::CH_SPACE);
    assign is_nul    = (i_byte == dap_pkg::CH_NUL);
    assign digit_val = {{(dap_pkg::VAL_W-4){1'b0}}, i_byte[3:0]};
    assign idx_less1 = r_idx - 3'd1;

    // Accumulator of the argument currently being built.
    always_comb begin
        acc_cur = '0;
        for (int i = 0; i < MAX_ARGS; i++) begin
            if (idx_less1[IDX_W-1:0] == IDX_W'(i)) begin
                acc_cur = r_acc[i];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_held  = r_held;
        wr_en   = 1'b0;
        wr_k    = idx_less1[IDX_W-1:0];
        wr_val  = digit_val;
        o_emit  = '0;
        o_emit.valid = is_nul;
        case (r_phase)
            dap_pkg::PH_LEAD: begin
                o_emit.status = dap_pkg::ST_EMPTY;
                if (!is_nul && !is_space) begin
                    if (i_byte == dap_pkg::CH_QUERY) begin
                        n_held  = dap_pkg::ST_HELP;
                        n_phase = dap_pkg::PH_DONE;
                    end else if (is_digit) begin
                        wr_en   = 1'b1;
                        wr_k    = '0;
                        n_idx   = 3'd1;
                        n_phase = dap_pkg::PH_NUM;
                    end else begin
                        n_held  = dap_pkg::ST_ERROR;
                        n_phase = dap_pkg::PH_DONE;
                    end
                end
            end
            dap_pkg::PH_NUM: begin
                o_emit.status = dap_pkg::ST_CORRECT;
                if (!is_nul) begin
                    if (is_digit) begin
                        wr_en  = 1'b1;
                        wr_val = (acc_cur << 3) + (acc_cur << 1) + digit_val;
                    end else if (is_space) begin
                        if (r_idx >= dap_pkg::CNT_W'(MAX_ARGS)) begin
                            n_held  = dap_pkg::ST_CORRECT;
                            n_phase = dap_pkg::PH_DONE;
                        end else begin
                            n_phase = dap_pkg::PH_GAP;
                        end
                    end else begin
                        n_held  = dap_pkg::ST_ERROR;
                        n_phase = dap_pkg::PH_DONE;
                    end
                end
            end
            dap_pkg::PH_GAP: begin
                o_emit.status = dap_pkg::ST_CORRECT;
                if (!is_nul && !is_space) begin
                    if (is_digit) begin
                        wr_en   = 1'b1;
                        wr_k    = r_idx[IDX_W-1:0];
                        n_idx   = r_idx + 3'd1;
                        n_phase = dap_pkg::PH_NUM;
                    end else begin
                        n_held  = dap_pkg::ST_ERROR;
                        n_phase = dap_pkg::PH_DONE;
                    end
                end
            end
            default: begin
                o_emit.status = r_held;
            end
        endcase
        if (o_emit.status == dap_pkg::ST_CORRECT) begin
            o_emit.count = r_idx;
        end
        if (is_nul) begin
            n_phase = dap_pkg::PH_LEAD;
            n_idx   = '0;
            n_held  = dap_pkg::ST_EMPTY;
        end
    end

    // Arguments beyond the count read as zero.
    always_comb begin
        for (int i = 0; i < dap_pkg::OUT_ARGS; i++) begin
            o_values[i] = '0;
        end
        for (int i = 0; i < MAX_ARGS; i++) begin
            if (dap_pkg::CNT_W'(i) < o_emit.count) begin
                o_values[i] = r_acc[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dap_pkg::PH_LEAD;
            r_idx   <= '0;
            r_held  <= dap_pkg::ST_EMPTY;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ARGS; i++) begin
            if (i_take && wr_en && (wr_k == IDX_W'(i))) begin
                r_acc[i] <= wr_val;
            end
        end
    end

endmodule

>>> rtl/decimal_argument_parser_top.sv
// ----------------------------------------------------------------------------
// Decimal argument parser
// Parses a zero-terminated ASCII argument string, one byte per transfer, into
// a status, an argument count and up to four unsigned decimal values.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         text_byte[7:0]
//  m_axis    out        parse_status[1:0], arg_count[4:2], value_0[36:5],
//                       value_1[68:37], value_2[100:69], value_3[132:101]
//
//  One byte is taken per clock cycle unless the input is stalled; the parse
//  state updates in the cycle of its transfer, and the result for a zero
//  byte is in the output register in the next cycle.
//  Reset is synchronous and active low; it returns the parser to the start
//  of a string and empties the output register.
//  The input is stalled only while a result waits and the output is not
//  ready; a result leaving in the same cycle frees the register for the next.
//
`timescale 1ns / 1ps
`include "decimal_argument_parser_top_macros.svh"

module decimal_argument_parser_top #(
    parameter int MAX_ARGS = dap_pkg::MAX_ARGS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [dap_pkg::BYTE_W-1:0]     i_s_axis_tdata,  // text_byte
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // parse_status, arg_count, value_0, value_1, value_2, value_3, zero pad
    output logic [dap_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int PAY_W = dap_pkg::STAT_W + dap_pkg::CNT_W
                         + dap_pkg::OUT_ARGS * dap_pkg::VAL_W;

    logic                      take;
    dap_pkg::t_emit            emit;
    logic [dap_pkg::VAL_W-1:0] values [dap_pkg::OUT_ARGS];
    logic                      r_out_valid;
    logic [PAY_W-1:0]          r_out_data;
    logic [PAY_W-1:0]          n_out_data;

    // The output register can take a new result when it is empty or when
    // its current result is transferred in the same cycle.
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign take            = i_s_axis_tvalid && o_s_axis_tready;

    dap_parse_core #(
        .MAX_ARGS (MAX_ARGS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (i_s_axis_tdata),
        .o_emit   (emit),
        .o_values (values)
    );

    assign n_out_data = {values[3], values[2], values[1], values[0], emit.count, emit.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit.valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(dap_pkg::OUT_DATA_W-PAY_W){1'b0}}, r_out_data};

    // A transferred zero byte always leaves a result in the output register.
    `DAP_ASSERT_NXT(a_nul_gives_result, i_clk, i_rst_n, take && (i_s_axis_tdata == dap_pkg::CH_NUL), o_m_axis_tvalid, "zero byte gave no result")

    // Only a correct parse reports arguments.
    `DAP_ASSERT_IMP(a_count_only_correct, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[1:0] != dap_pkg::ST_CORRECT), (o_m_axis_tdata[4:2] == '0) && (o_m_axis_tdata[132:5] == '0), "non-correct result carries arguments")

    // The count never exceeds the argument limit.
    `DAP_ASSERT_IMP(a_count_limit, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tdata[4:2] <= dap_pkg::CNT_W'(MAX_ARGS), "argument count beyond limit")

    // A non-zero byte never produces a fresh result.
    `DAP_ASSERT_NXT(a_no_spurious, i_clk, i_rst_n, !o_m_axis_tvalid && !(take && (i_s_axis_tdata == dap_pkg::CH_NUL)), !o_m_axis_tvalid, "result without zero byte")

endmodule

>>> tb/decimal_argument_parser_checker.sv
// ----------------------------------------------------------------------------
// Decimal argument parser checker
// Watches both stream channels, keeps its own model of the parser state,
// queues the result predicted for every terminating byte and compares each
// output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module decimal_argument_parser_checker
    import dap_pkg::*;
#(
    parameter int MAX_ARGS = MAX_ARGS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,  // text_byte
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // parse_status, arg_count, value_0, value_1, value_2, value_3, zero pad
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int CNT_LO = STAT_W;
    localparam int VAL_LO = STAT_W + CNT_W;
    localparam int PAD_LO = VAL_LO + OUT_ARGS * VAL_W;

    typedef struct packed {
        logic [STAT_W-1:0]                 status;
        logic [CNT_W-1:0]                  count;
        logic [OUT_ARGS-1:0][VAL_W-1:0]    values;
    } t_parse_result;

    // Model of the parser state.
    logic [PHASE_W-1:0] model_phase;
    logic [CNT_W-1:0]   model_index;
    logic [VAL_W-1:0]   model_acc [OUT_ARGS];
    logic [STAT_W-1:0]  model_held;

    t_parse_result expected_results [$];
    int            fail_total;

    task automatic clear_model();
        int i;
        model_phase = PH_LEAD;
        model_index = '0;
        for (i = 0; i < OUT_ARGS; i++) model_acc[i] = '0;
        model_held = ST_EMPTY;
    endtask

    task automatic close_string(input logic [STAT_W-1:0] status,
                                input logic [CNT_W-1:0] count,
                                output t_parse_result res);
        int i;
        res = '0;
        res.status = status;
        res.count  = (status == ST_CORRECT) ? count : '0;
        for (i = 0; i < OUT_ARGS; i++) begin
            if (CNT_W'(i) < res.count) res.values[i] = model_acc[i];
        end
        clear_model();
    endtask

    // Advances the model by one text byte; a zero byte closes the string.
    task automatic parse_text_byte(input logic [BYTE_W-1:0] ch,
                                   output bit produced,
                                   output t_parse_result res);
        logic             is_digit;
        logic             is_space;
        logic [VAL_W-1:0] digit;
        logic [1:0]       slot;
        produced = 1'b0;
        res      = '0;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        is_space = (ch == CH_SPACE);
        digit    = VAL_W'(ch - CH_ZERO);
        case (model_phase)
            PH_LEAD: begin
                if (ch == CH_NUL) begin
                    close_string(ST_EMPTY, '0, res);
                    produced = 1'b1;
                end else if (is_space) begin
                end else if (ch == CH_QUERY) begin
                    model_held  = ST_HELP;
                    model_phase = PH_DONE;
                end else if (is_digit) begin
                    model_acc[0] = digit;
                    model_index  = 3'd1;
                    model_phase  = PH_NUM;
                end else begin
                    model_held  = ST_ERROR;
                    model_phase = PH_DONE;
                end
            end
            PH_NUM: begin
                slot = 2'(model_index - 3'd1);
                if (ch == CH_NUL) begin
                    close_string(ST_CORRECT, model_index, res);
                    produced = 1'b1;
                end else if (is_digit) begin
                    model_acc[slot] = model_acc[slot] * 32'd10 + digit;
                end else if (is_space) begin
                    if (model_index >= CNT_W'(MAX_ARGS)) begin
                        model_held  = ST_CORRECT;
                        model_phase = PH_DONE;
                    end else begin
                        model_phase = PH_GAP;
                    end
                end else begin
                    model_held  = ST_ERROR;
                    model_phase = PH_DONE;
                end
            end
            PH_GAP: begin
                slot = model_index[1:0];
                if (ch == CH_NUL) begin
                    close_string(ST_CORRECT, model_index, res);
                    produced = 1'b1;
                end else if (is_space) begin
                end else if (is_digit) begin
                    model_acc[slot] = digit;
                    model_index     = model_index + 3'd1;
                    model_phase     = PH_NUM;
                end else begin
                    model_held  = ST_ERROR;
                    model_phase = PH_DONE;
                end
            end
            default: begin
                if (ch == CH_NUL) begin
                    close_string(model_held, model_index, res);
                    produced = 1'b1;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
        fail_total++;
    endtask

    initial begin
        fail_total = 0;
        clear_model();
    end

    always @(posedge i_clk) begin
        t_parse_result    want;
        t_parse_result    got;
        bit               produced;
        logic [OUT_DATA_W-PAD_LO-1:0] pad;
        int               i;
        if (!i_rst_n) begin
            clear_model();
            expected_results.delete();
        end else begin
            // Output first: a result never leaves at the edge of its own byte.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status = i_m_axis_tdata[CNT_LO-1:0];
                got.count  = i_m_axis_tdata[VAL_LO-1:CNT_LO];
                for (i = 0; i < OUT_ARGS; i++)
                    got.values[i] = i_m_axis_tdata[VAL_LO + i*VAL_W +: VAL_W];
                pad = i_m_axis_tdata[OUT_DATA_W-1:PAD_LO];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending, status",
                                    VAL_W'(got.status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("parse_status", VAL_W'(got.status),
                                        VAL_W'(want.status));
                    if (got.count !== want.count)
                        report_mismatch("arg_count", VAL_W'(got.count),
                                        VAL_W'(want.count));
                    for (i = 0; i < OUT_ARGS; i++) begin
                        if (got.values[i] !== want.values[i])
                            report_mismatch($sformatf("value_%0d", i), got.values[i],
                                            want.values[i]);
                    end
                    if (pad !== '0) report_mismatch("tdata padding", VAL_W'(pad), '0);
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                parse_text_byte(i_s_axis_tdata, produced, want);
                if (produced) expected_results.push_back(want);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> tb/tb_decimal_argument_parser_top.sv
// ----------------------------------------------------------------------------
// Decimal argument parser testbench
// Feeds zero-terminated argument strings into the parser byte by byte, first
// a handful of hand-picked strings and then a long run of random ones, with
// random idle bursts on both channels and one long output stall. A separate
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_decimal_argument_parser_top;
    import dap_pkg::*;

    // Rough byte budget: directed strings plus about 750 random bytes.
    localparam int TOTAL_BYTES      = 770;
    // From this byte on neither side idles any more.
    localparam int QUIET_FROM       = 680;
    // The long output stall starts once this many bytes have been taken.
    localparam int LONG_HOLD_AT     = 200;
    localparam int LONG_HOLD_CYCLES = 80;
    // Watchdog limit for the whole run; it leaves ample margin over a legal run.
    localparam int CYCLE_LIMIT      = 100000;
    localparam int TAIL_CYCLES      = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_data;
    logic                  m_valid;
    logic                  m_ready;
    logic [OUT_DATA_W-1:0] m_data;

    int fail_count;
    int pending;
    int bytes_sent;
    int cycle_count;
    int long_hold_left;
    int ready_gap_left;
    bit long_hold_done;

    // Bytes of the string that is being built up before it is sent.
    logic [BYTE_W-1:0] text_q [$];

    decimal_argument_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    decimal_argument_parser_checker checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver. It drops tready in random bursts until the quiet part of the
    // run, and once holds it low for a long stretch so that the output
    // register fills and the parser has to stall its input.
    always @(negedge i_clk) begin
        if (!long_hold_done && bytes_sent >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD_CYCLES;
        end
        if (long_hold_left > 0) begin
            long_hold_left--;
            m_ready <= 1'b0;
        end else if (ready_gap_left > 0) begin
            ready_gap_left--;
            m_ready <= 1'b0;
        end else if (bytes_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
            ready_gap_left = $urandom_range(1, 10) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic add_spaces(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) text_q.push_back(CH_SPACE);
    endtask

    // A decimal number, mostly short, sometimes long enough to wrap.
    task automatic add_number();
        int n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
        repeat (n) text_q.push_back(CH_ZERO + BYTE_W'($urandom_range(0, 9)));
    endtask

    // Any non-zero byte; what the parser makes of it depends on where it falls.
    task automatic add_junk(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) text_q.push_back(BYTE_W'($urandom_range(1, 255)));
    endtask

    // A byte that is neither a digit, nor a space, nor the terminator.
    task automatic add_bad_char();
        logic [BYTE_W-1:0] ch;
        if ($urandom_range(0, 3) == 0) begin
            ch = CH_QUERY;
        end else begin
            ch = BYTE_W'($urandom_range(1, 255));
            while (ch == CH_SPACE || (ch >= CH_ZERO && ch <= CH_NINE))
                ch = BYTE_W'($urandom_range(1, 255));
        end
        text_q.push_back(ch);
    endtask

    // One transfer on the input channel. Changes are made at the falling
    // edge and tready is sampled at the rising edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (bytes_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Closes the string being built with a zero byte and sends it whole.
    task automatic send_text();
        text_q.push_back(CH_NUL);
        while (text_q.size() > 0) send_byte(text_q.pop_front());
    endtask

    // Builds one random string. Most are well-formed argument lists, the
    // rest are help requests, broken lists, noise and blank strings.
    task automatic build_random_text();
        int kind;
        int nargs;
        int i;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            add_spaces(0, 3);
            nargs = $urandom_range(1, 6);
            for (i = 0; i < nargs; i++) begin
                add_number();
                if (i < nargs - 1) add_spaces(1, 3);
            end
            add_spaces(0, 2);
            // Past the argument limit anything at all is ignored.
            if (nargs >= MAX_ARGS_DEF && $urandom_range(0, 1) == 0) begin
                text_q.push_back(CH_SPACE);
                add_junk(1, 4);
            end
        end else if (kind == 6) begin
            add_spaces(0, 2);
            text_q.push_back(CH_QUERY);
            add_junk(0, 4);
        end else if (kind == 7) begin
            add_spaces(0, 2);
            nargs = $urandom_range(0, 3);
            for (i = 0; i < nargs; i++) begin
                add_number();
                add_spaces(0, 2);
            end
            add_bad_char();
            add_junk(0, 3);
        end else if (kind == 8) begin
            add_junk(1, 8);
        end else begin
            add_spaces(0, 3);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        bytes_sent     = 0;
        cycle_count    = 0;
        long_hold_left = 0;
        ready_gap_left = 0;
        long_hold_done = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: an empty string; a lone help marker; a '?' after
        // a number, which is an error; a byte with the top bit set; the
        // argument limit with ignored text after it; trailing spaces.
        send_text();
        add_text("?");
        send_text();
        add_text(" 7?");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        add_text("1 2 3 4 #");
        send_text();
        add_text("5  ");
        send_text();

        // Random strings until the byte budget is spent.
        while (bytes_sent < TOTAL_BYTES) begin
            build_random_text();
            send_text();
        end
        s_valid <= 1'b0;

        // Let every predicted result drain, then a short tail for strays.
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/dap_pkg.sv
rtl/dap_parse_core.sv
rtl/decimal_argument_parser_top.sv
tb/decimal_argument_parser_checker.sv
tb/tb_decimal_argument_parser_top.sv
